[sv/mzbt_pkg.sv]
`default_nettype none
package mzbt_pkg;

    localparam int MAX_COLUMNS = 32;
    localparam int MAX_ROWS    = 32;
    localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;

    localparam int COL_W      = $clog2(MAX_COLUMNS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int GRID_AW    = COL_W + ROW_W;
    localparam int GRID_DEPTH = 1 << GRID_AW;
    localparam int STK_AW     = $clog2(CELL_COUNT);
    localparam int DEPTH_W    = $clog2(CELL_COUNT + 1);
    localparam int EW         = $clog2(MAX_COLUMNS + 1);
    localparam int EH         = $clog2(MAX_ROWS + 1);
    localparam int AREA_W     = EW + EH;

    localparam int CMD_W     = 2;
    localparam int XY_W      = 5;
    localparam int PICK_W    = 8;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 6'd10;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 6'd10;

    localparam logic [1:0] DIR_RIGHT  = 2'd0;
    localparam logic [1:0] DIR_LEFT   = 2'd1;
    localparam logic [1:0] DIR_BOTTOM = 2'd2;
    localparam logic [1:0] DIR_TOP    = 2'd3;

    localparam logic SIDE_RIGHT  = 1'b0;
    localparam logic SIDE_BOTTOM = 1'b1;

    typedef struct packed {
        logic [ROW_W-1:0] y;
        logic [COL_W-1:0] x;
    } t_cell;

    typedef struct packed {
        logic  vis_we;
        logic  vis_wd;
        t_cell vis_wa;
        logic  rgt_we;
        logic  bot_we;
        logic  wall_wd;
        t_cell wall_wa;
        t_cell ra;
    } t_grid_req;

    typedef struct packed {
        logic vis;
        logic rgt;
        logic bot;
    } t_grid_rsp;

    typedef struct packed {
        logic              we;
        logic [STK_AW-1:0] wa;
        t_cell             wd;
        logic [STK_AW-1:0] ra;
    } t_stk_req;

    typedef struct packed {
        logic               busy;
        logic [DEPTH_W-1:0] depth;
        logic [DEPTH_W-1:0] vcount;
    } t_ctrl_sts;

    typedef struct packed {
        logic            carved;
        logic            popped;
        logic            finished;
        logic [XY_W-1:0] wall_x;
        logic [XY_W-1:0] wall_y;
        logic            wall_side;
        logic            right_wall;
        logic            bottom_wall;
    } t_result;

endpackage
`default_nettype wire

[sv/maze_backtracker_step.sv]
// Step: stack top read, four neighbor reads, then decide; when the maze is finished or the
// stack is empty it goes straight to the result, as does a no-operation. Read: one grid
// read, then the result. Start: a one-cell-per-cycle clearing sweep of the 1024-cell grid.
// One request is served at a time. After reset a clearing sweep runs with o_stall high;
// config writes are taken at any time. A finished result waits in the output register.
`default_nettype none
module maze_backtracker_step (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [mzbt_pkg::CMD_W-1:0]          i_command,
    input  logic [mzbt_pkg::XY_W-1:0]           i_cell_x,
    input  logic [mzbt_pkg::XY_W-1:0]           i_cell_y,
    input  logic [mzbt_pkg::PICK_W-1:0]         i_random_pick,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_carved,
    output logic                                o_popped,
    output logic                                o_finished,
    output logic [mzbt_pkg::XY_W-1:0]           o_wall_x,
    output logic [mzbt_pkg::XY_W-1:0]           o_wall_y,
    output logic                                o_wall_side,
    output logic                                o_right_wall,
    output logic                                o_bottom_wall,
    input  logic                                i_cfg_we,
    input  logic [mzbt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mzbt_pkg::CFG_W-1:0]          i_cfg_data
);
    import mzbt_pkg::*;

    logic [CFG_W-1:0]  r_maze_width;
    logic [CFG_W-1:0]  r_maze_height;
    logic [EW-1:0]     w_eff_w;
    logic [EH-1:0]     w_eff_h;
    logic [AREA_W-1:0] w_area;
    logic              w_finished;
    t_grid_req         w_grid_req;
    t_grid_rsp         w_grid_rsp;
    t_stk_req          w_stk_req;
    t_cell             w_stk_rdata;
    t_ctrl_sts         w_sts;
    t_result           w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maze_width  <= WIDTH_RESET;
            r_maze_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_maze_width  <= i_cfg_data;
                CFG_HEIGHT: r_maze_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_eff_w = (r_maze_width == '0) ? EW'(1) :
                     (int'(r_maze_width) > MAX_COLUMNS) ? EW'(MAX_COLUMNS) :
                     EW'(r_maze_width);
    assign w_eff_h = (r_maze_height == '0) ? EH'(1) :
                     (int'(r_maze_height) > MAX_ROWS) ? EH'(MAX_ROWS) :
                     EH'(r_maze_height);
    assign w_area     = AREA_W'(w_eff_w) * AREA_W'(w_eff_h);
    assign w_finished = int'(w_sts.vcount) >= int'(w_area);

    mzbt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_command     (i_command),
        .i_cell_x      (i_cell_x),
        .i_cell_y      (i_cell_y),
        .i_random_pick (i_random_pick),
        .i_eff_w       (w_eff_w),
        .i_eff_h       (w_eff_h),
        .i_finished    (w_finished),
        .i_out_stall   (i_stall),
        .o_grid_req    (w_grid_req),
        .i_grid_rsp    (w_grid_rsp),
        .o_stk_req     (w_stk_req),
        .i_stk_rdata   (w_stk_rdata),
        .o_sts         (w_sts),
        .o_out_valid   (o_valid),
        .o_result      (w_result)
    );

    mzbt_grid u_grid (
        .i_clk (i_clk),
        .i_req (w_grid_req),
        .o_rsp (w_grid_rsp)
    );

    mzbt_stack u_stack (
        .i_clk   (i_clk),
        .i_req   (w_stk_req),
        .o_rdata (w_stk_rdata)
    );

    assign o_stall       = w_sts.busy;
    assign o_carved      = w_result.carved;
    assign o_popped      = w_result.popped;
    assign o_finished    = w_result.finished;
    assign o_wall_x      = w_result.wall_x;
    assign o_wall_y      = w_result.wall_y;
    assign o_wall_side   = w_result.wall_side;
    assign o_right_wall  = w_result.right_wall;
    assign o_bottom_wall = w_result.bottom_wall;

`ifndef SYNTHESIS
    a_depth_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.depth <= w_sts.vcount)
        else $error("stack holds more cells than were visited");

    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(w_sts.depth) <= CELL_COUNT)
        else $error("stack depth beyond capacity");

    a_carve_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_carved |-> !o_popped && !o_right_wall && !o_bottom_wall)
        else $error("carve result mixed with pop or read fields");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted request did not make the block busy");
`endif

endmodule
`default_nettype wire

[sv/mzbt_grid.sv]
`default_nettype none
module mzbt_grid (
    input  logic                i_clk,
    input  mzbt_pkg::t_grid_req i_req,
    output mzbt_pkg::t_grid_rsp o_rsp
);
    import mzbt_pkg::*;

    logic      r_vis_mem [GRID_DEPTH];
    logic      r_rgt_mem [GRID_DEPTH];
    logic      r_bot_mem [GRID_DEPTH];
    t_grid_rsp r_rsp;

    always_ff @(posedge i_clk) begin
        if (i_req.vis_we) begin
            r_vis_mem[i_req.vis_wa] <= i_req.vis_wd;
        end
        if (i_req.rgt_we) begin
            r_rgt_mem[i_req.wall_wa] <= i_req.wall_wd;
        end
        if (i_req.bot_we) begin
            r_bot_mem[i_req.wall_wa] <= i_req.wall_wd;
        end
        r_rsp.vis <= r_vis_mem[i_req.ra];
        r_rsp.rgt <= r_rgt_mem[i_req.ra];
        r_rsp.bot <= r_bot_mem[i_req.ra];
    end

    assign o_rsp = r_rsp;

endmodule
`default_nettype wire

[sv/mzbt_stack.sv]
`default_nettype none
module mzbt_stack (
    input  logic               i_clk,
    input  mzbt_pkg::t_stk_req i_req,
    output mzbt_pkg::t_cell    o_rdata
);
    import mzbt_pkg::*;

    t_cell r_mem [CELL_COUNT];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wa] <= i_req.wd;
        end
        r_rdata <= r_mem[i_req.ra];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[sv/mzbt_ctrl.sv]
`default_nettype none
module mzbt_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [mzbt_pkg::CMD_W-1:0]       i_command,
    input  logic [mzbt_pkg::XY_W-1:0]        i_cell_x,
    input  logic [mzbt_pkg::XY_W-1:0]        i_cell_y,
    input  logic [mzbt_pkg::PICK_W-1:0]      i_random_pick,
    input  logic [mzbt_pkg::EW-1:0]          i_eff_w,
    input  logic [mzbt_pkg::EH-1:0]          i_eff_h,
    input  logic                             i_finished,
    input  logic                             i_out_stall,
    output mzbt_pkg::t_grid_req              o_grid_req,
    input  mzbt_pkg::t_grid_rsp              i_grid_rsp,
    output mzbt_pkg::t_stk_req               o_stk_req,
    input  mzbt_pkg::t_cell                  i_stk_rdata,
    output mzbt_pkg::t_ctrl_sts              o_sts,
    output logic                             o_out_valid,
    output mzbt_pkg::t_result                o_result
);
    import mzbt_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_TOP  = 3'd2;
    localparam logic [2:0] S_NB   = 3'd3;
    localparam logic [2:0] S_DEC  = 3'd4;
    localparam logic [2:0] S_RD   = 3'd5;
    localparam logic [2:0] S_RDQ  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]         r_state,    n_state;
    logic [GRID_AW-1:0] r_clr_cnt,  n_clr_cnt;
    logic               r_clr_fin,  n_clr_fin;
    logic [DEPTH_W-1:0] r_depth,    n_depth;
    logic [DEPTH_W-1:0] r_vcount,   n_vcount;
    t_cell              r_top,      n_top;
    t_cell              r_rd_cell,  n_rd_cell;
    logic [PICK_W-1:0]  r_pick,     n_pick;
    logic [1:0]         r_dir,      n_dir;
    logic               r_pend_v,   n_pend_v;
    logic               r_pend_ok,  n_pend_ok;
    logic [1:0]         r_pend_dir, n_pend_dir;
    logic [3:0]         r_cand,     n_cand;
    t_result            r_res,      n_res;
    logic               r_out_valid, n_out_valid;
    t_result            r_out,      n_out;

    logic        w_accept;
    logic        w_hit;
    logic [3:0]  w_mask;
    logic [2:0]  w_cnt;
    logic [15:0] w_prod;
    logic [6:0]  w_quot;
    logic [7:0]  w_rem3;
    logic [1:0]  w_sel;
    logic [2:0]  w_idx;
    logic        w_found;
    logic [1:0]  w_dir;
    t_cell       w_next;
    t_cell       w_owner;
    logic        w_side;
    t_cell       w_start;
    t_cell       w_read;

    function automatic t_cell nb_cell(t_cell c, logic [1:0] d);
        t_cell r;
        r = c;
        case (d)
            DIR_RIGHT:  r.x = c.x + 1'b1;
            DIR_LEFT:   r.x = c.x - 1'b1;
            DIR_BOTTOM: r.y = c.y + 1'b1;
            default:    r.y = c.y - 1'b1;
        endcase
        return r;
    endfunction

    function automatic logic in_bounds(t_cell c, logic [1:0] d,
                                       logic [EW-1:0] w, logic [EH-1:0] h);
        logic ok;
        case (d)
            DIR_RIGHT:  ok = (int'(c.x) + 1) < int'(w);
            DIR_LEFT:   ok = c.x != '0;
            DIR_BOTTOM: ok = (int'(c.y) + 1) < int'(h);
            default:    ok = c.y != '0;
        endcase
        return ok;
    endfunction

    assign w_accept = i_valid && (r_state == S_IDLE);
    assign w_hit    = r_pend_v && r_pend_ok && !i_grid_rsp.vis;
    assign w_mask   = r_cand | (w_hit ? (4'b0001 << r_pend_dir) : 4'b0000);

    assign w_start.x = (int'(i_cell_x) >= int'(i_eff_w)) ? COL_W'(i_eff_w - 1'b1)
                                                         : COL_W'(i_cell_x);
    assign w_start.y = (int'(i_cell_y) >= int'(i_eff_h)) ? ROW_W'(i_eff_h - 1'b1)
                                                         : ROW_W'(i_cell_y);
    assign w_read.x  = (int'(i_cell_x) >= MAX_COLUMNS) ? COL_W'(MAX_COLUMNS - 1)
                                                       : COL_W'(i_cell_x);
    assign w_read.y  = (int'(i_cell_y) >= MAX_ROWS) ? ROW_W'(MAX_ROWS - 1)
                                                    : ROW_W'(i_cell_y);

    // Neighbor choice: count candidates, reduce the pick, take the selected set bit.
    assign w_prod = 16'(r_pick) * 16'd171;
    assign w_quot = w_prod[15:9];
    assign w_rem3 = r_pick - 8'(10'(w_quot) * 10'd3);

    always_comb begin
        w_cnt = '0;
        for (int k = 0; k < 4; k++) begin
            w_cnt = w_cnt + 3'(w_mask[k]);
        end
        case (w_cnt)
            3'd2:    w_sel = {1'b0, r_pick[0]};
            3'd3:    w_sel = w_rem3[1:0];
            3'd4:    w_sel = r_pick[1:0];
            default: w_sel = 2'd0;
        endcase
        w_dir   = DIR_RIGHT;
        w_found = 1'b0;
        w_idx   = '0;
        for (int k = 0; k < 4; k++) begin
            if (w_mask[k]) begin
                if (!w_found && (w_idx == {1'b0, w_sel})) begin
                    w_dir   = 2'(k);
                    w_found = 1'b1;
                end
                w_idx = w_idx + 1'b1;
            end
        end
        w_next  = nb_cell(r_top, w_dir);
        w_owner = ((w_dir == DIR_RIGHT) || (w_dir == DIR_BOTTOM)) ? r_top : w_next;
        w_side  = ((w_dir == DIR_BOTTOM) || (w_dir == DIR_TOP)) ? SIDE_BOTTOM : SIDE_RIGHT;
    end

    always_comb begin
        o_grid_req         = '0;
        o_grid_req.ra      = r_rd_cell;
        o_stk_req          = '0;
        o_stk_req.ra       = STK_AW'(r_depth - 1'b1);

        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_clr_fin   = r_clr_fin;
        n_depth     = r_depth;
        n_vcount    = r_vcount;
        n_top       = r_top;
        n_rd_cell   = r_rd_cell;
        n_pick      = r_pick;
        n_dir       = r_dir;
        n_pend_v    = r_pend_v;
        n_pend_ok   = r_pend_ok;
        n_pend_dir  = r_pend_dir;
        n_cand      = r_cand;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_CLR: begin
                o_grid_req.vis_we  = 1'b1;
                o_grid_req.vis_wd  = 1'b0;
                o_grid_req.vis_wa  = t_cell'(r_clr_cnt);
                o_grid_req.rgt_we  = 1'b1;
                o_grid_req.bot_we  = 1'b1;
                o_grid_req.wall_wd = 1'b1;
                o_grid_req.wall_wa = t_cell'(r_clr_cnt);
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (&r_clr_cnt) begin
                    n_state = r_clr_fin ? S_FIN : S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_res = '0;
                    unique case (i_command)
                        CMD_START: begin
                            o_stk_req.we = 1'b1;
                            o_stk_req.wa = '0;
                            o_stk_req.wd = w_start;
                            n_depth   = DEPTH_W'(1);
                            n_vcount  = DEPTH_W'(1);
                            n_clr_cnt = '0;
                            n_clr_fin = 1'b1;
                            n_state   = S_CLR;
                        end
                        CMD_STEP: begin
                            n_pick = i_random_pick;
                            if (i_finished || (r_depth == '0)) begin
                                n_state = S_FIN;
                            end else begin
                                n_state = S_TOP;
                            end
                        end
                        CMD_READ: begin
                            n_rd_cell = w_read;
                            n_state   = S_RD;
                        end
                        CMD_NOP: begin
                            n_state = S_FIN;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_TOP: begin
                o_grid_req.vis_we = 1'b1;
                o_grid_req.vis_wd = 1'b1;
                o_grid_req.vis_wa = i_stk_rdata;
                n_top    = i_stk_rdata;
                n_dir    = DIR_RIGHT;
                n_pend_v = 1'b0;
                n_cand   = '0;
                n_state  = S_NB;
            end
            S_NB: begin
                o_grid_req.ra = nb_cell(r_top, r_dir);
                n_pend_ok  = in_bounds(r_top, r_dir, i_eff_w, i_eff_h);
                n_pend_dir = r_dir;
                n_pend_v   = 1'b1;
                n_cand     = w_mask;
                n_dir      = r_dir + 2'd1;
                if (r_dir == DIR_TOP) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (w_cnt == '0) begin
                    n_depth      = r_depth - 1'b1;
                    n_res.popped = 1'b1;
                end else begin
                    o_grid_req.rgt_we  = (w_side == SIDE_RIGHT);
                    o_grid_req.bot_we  = (w_side == SIDE_BOTTOM);
                    o_grid_req.wall_wd = 1'b0;
                    o_grid_req.wall_wa = w_owner;
                    if (int'(r_depth) < CELL_COUNT) begin
                        o_stk_req.we = 1'b1;
                        o_stk_req.wa = STK_AW'(r_depth);
                        o_stk_req.wd = w_next;
                        n_depth      = r_depth + 1'b1;
                    end
                    n_vcount        = r_vcount + 1'b1;
                    n_res.carved    = 1'b1;
                    n_res.wall_x    = XY_W'(w_owner.x);
                    n_res.wall_y    = XY_W'(w_owner.y);
                    n_res.wall_side = w_side;
                end
                n_state = S_FIN;
            end
            S_RD: begin
                n_state = S_RDQ;
            end
            S_RDQ: begin
                n_res.wall_x      = XY_W'(r_rd_cell.x);
                n_res.wall_y      = XY_W'(r_rd_cell.y);
                n_res.right_wall  = i_grid_rsp.rgt;
                n_res.bottom_wall = i_grid_rsp.bot;
                n_state           = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out          = r_res;
                    n_out.finished = i_finished;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_cnt   <= '0;
            r_clr_fin   <= 1'b0;
            r_depth     <= '0;
            r_vcount    <= '0;
            r_out_valid <= 1'b0;
            r_pend_v    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_clr_fin   <= n_clr_fin;
            r_depth     <= n_depth;
            r_vcount    <= n_vcount;
            r_out_valid <= n_out_valid;
            r_pend_v    <= n_pend_v;
        end
        r_top      <= n_top;
        r_rd_cell  <= n_rd_cell;
        r_pick     <= n_pick;
        r_dir      <= n_dir;
        r_pend_ok  <= n_pend_ok;
        r_pend_dir <= n_pend_dir;
        r_cand     <= n_cand;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_sts.busy   = (r_state != S_IDLE);
    assign o_sts.depth  = r_depth;
    assign o_sts.vcount = r_vcount;
    assign o_out_valid  = r_out_valid;
    assign o_result     = r_out;

endmodule
`default_nettype wire

[test/tb_maze_backtracker_step.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_maze_backtracker_step;
    import mzbt_pkg::*;

    localparam int CYCLE_LIMIT = 8000000;
    localparam int RANDOM_REQUESTS = 1000;

    class maze_tracker;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        bit visited[CELL_COUNT];
        bit right_wall_up[CELL_COUNT];
        bit bottom_wall_up[CELL_COUNT];
        int cell_stack[CELL_COUNT];
        int stack_depth;
        int visited_count;
        t_result queued_outcomes[$];
        int errors;
        int results_seen;

        function new();
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            for (int i = 0; i < CELL_COUNT; i++) begin
                visited[i] = 1'b0;
                right_wall_up[i] = 1'b1;
                bottom_wall_up[i] = 1'b1;
                cell_stack[i] = 0;
            end
            stack_depth = 0;
            visited_count = 0;
            errors = 0;
            results_seen = 0;
        endfunction

        function void set_size(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
            if (index == CFG_WIDTH) begin
                width_reg = value;
            end else begin
                height_reg = value;
            end
        endfunction

        function int columns();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_COLUMNS) return MAX_COLUMNS;
            return int'(width_reg);
        endfunction

        function int rows();
            if (height_reg == 0) return 1;
            if (height_reg > MAX_ROWS) return MAX_ROWS;
            return int'(height_reg);
        endfunction

        function bit maze_done();
            return visited_count >= columns() * rows();
        endfunction

        function int pending();
            return queued_outcomes.size();
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [XY_W-1:0] cx,
                                   logic [XY_W-1:0] cy, logic [PICK_W-1:0] pick);
            t_result r;
            int w;
            int h;
            int x;
            int y;
            int top;
            int tx;
            int ty;
            int n;
            int sel;
            int nxt;
            int owner;
            logic side;
            int cand[4];
            logic [1:0] dirs[4];
            r = '0;
            w = columns();
            h = rows();
            x = int'(cx);
            y = int'(cy);
            case (cmd)
                CMD_START: begin
                    if (x >= w) x = w - 1;
                    if (y >= h) y = h - 1;
                    for (int i = 0; i < CELL_COUNT; i++) begin
                        visited[i] = 1'b0;
                        right_wall_up[i] = 1'b1;
                        bottom_wall_up[i] = 1'b1;
                    end
                    cell_stack[0] = y * MAX_COLUMNS + x;
                    stack_depth = 1;
                    visited_count = 1;
                end
                CMD_STEP: begin
                    if (!maze_done() && stack_depth > 0) begin
                        top = cell_stack[stack_depth - 1];
                        tx = top % MAX_COLUMNS;
                        ty = top / MAX_COLUMNS;
                        visited[top] = 1'b1;
                        n = 0;
                        if (tx + 1 < w && !visited[top + 1]) begin
                            cand[n] = top + 1;
                            dirs[n] = DIR_RIGHT;
                            n++;
                        end
                        if (tx >= 1 && !visited[top - 1]) begin
                            cand[n] = top - 1;
                            dirs[n] = DIR_LEFT;
                            n++;
                        end
                        if (ty + 1 < h && !visited[top + MAX_COLUMNS]) begin
                            cand[n] = top + MAX_COLUMNS;
                            dirs[n] = DIR_BOTTOM;
                            n++;
                        end
                        if (ty >= 1 && !visited[top - MAX_COLUMNS]) begin
                            cand[n] = top - MAX_COLUMNS;
                            dirs[n] = DIR_TOP;
                            n++;
                        end
                        if (n == 0) begin
                            stack_depth--;
                            r.popped = 1'b1;
                        end else begin
                            sel = int'(pick) % n;
                            nxt = cand[sel];
                            case (dirs[sel])
                                DIR_RIGHT: begin
                                    owner = top;
                                    side = SIDE_RIGHT;
                                end
                                DIR_LEFT: begin
                                    owner = nxt;
                                    side = SIDE_RIGHT;
                                end
                                DIR_BOTTOM: begin
                                    owner = top;
                                    side = SIDE_BOTTOM;
                                end
                                default: begin
                                    owner = nxt;
                                    side = SIDE_BOTTOM;
                                end
                            endcase
                            if (side == SIDE_RIGHT) begin
                                right_wall_up[owner] = 1'b0;
                            end else begin
                                bottom_wall_up[owner] = 1'b0;
                            end
                            if (stack_depth < CELL_COUNT) begin
                                cell_stack[stack_depth] = nxt;
                                stack_depth++;
                            end
                            visited_count++;
                            r.carved = 1'b1;
                            r.wall_x = XY_W'(owner % MAX_COLUMNS);
                            r.wall_y = XY_W'(owner / MAX_COLUMNS);
                            r.wall_side = side;
                        end
                    end
                end
                CMD_READ: begin
                    if (x >= MAX_COLUMNS) x = MAX_COLUMNS - 1;
                    if (y >= MAX_ROWS) y = MAX_ROWS - 1;
                    r.wall_x = XY_W'(x);
                    r.wall_y = XY_W'(y);
                    r.right_wall = right_wall_up[y * MAX_COLUMNS + x];
                    r.bottom_wall = bottom_wall_up[y * MAX_COLUMNS + x];
                end
                default: begin
                end
            endcase
            r.finished = maze_done();
            queued_outcomes.insert(queued_outcomes.size(), r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("mismatch: %s", msg);
        endtask

        task compare_field(string field, int got, int want);
            if (got != want) begin
                report($sformatf("result %0d field %s got %0d want %0d",
                                 results_seen, field, got, want));
            end
        endtask

        task check_result(t_result got);
            t_result want;
            if (queued_outcomes.size() == 0) begin
                report($sformatf("result %0d arrived with no request pending", results_seen));
            end else begin
                want = queued_outcomes.pop_front();
                compare_field("carved", got.carved, want.carved);
                compare_field("popped", got.popped, want.popped);
                compare_field("finished", got.finished, want.finished);
                compare_field("wall_x", got.wall_x, want.wall_x);
                compare_field("wall_y", got.wall_y, want.wall_y);
                compare_field("wall_side", got.wall_side, want.wall_side);
                compare_field("right_wall", got.right_wall, want.right_wall);
                compare_field("bottom_wall", got.bottom_wall, want.bottom_wall);
            end
            results_seen++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic [CMD_W-1:0] i_command;
    logic [XY_W-1:0] i_cell_x;
    logic [XY_W-1:0] i_cell_y;
    logic [PICK_W-1:0] i_random_pick;
    logic o_valid;
    logic i_stall;
    logic o_carved;
    logic o_popped;
    logic o_finished;
    logic [XY_W-1:0] o_wall_x;
    logic [XY_W-1:0] o_wall_y;
    logic o_wall_side;
    logic o_right_wall;
    logic o_bottom_wall;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    maze_tracker tracker = new();
    int requests_sent = 0;
    bit no_gaps = 1'b0;

    maze_backtracker_step DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_command(i_command),
        .i_cell_x(i_cell_x),
        .i_cell_y(i_cell_y),
        .i_random_pick(i_random_pick),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_carved(o_carved),
        .o_popped(o_popped),
        .o_finished(o_finished),
        .o_wall_x(o_wall_x),
        .o_wall_y(o_wall_y),
        .o_wall_side(o_wall_side),
        .o_right_wall(o_right_wall),
        .o_bottom_wall(o_bottom_wall),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.carved = o_carved;
            got.popped = o_popped;
            got.finished = o_finished;
            got.wall_x = o_wall_x;
            got.wall_y = o_wall_y;
            got.wall_side = o_wall_side;
            got.right_wall = o_right_wall;
            got.bottom_wall = o_bottom_wall;
            tracker.check_result(got);
        end
    end

    initial begin
        int k;
        int len;
        i_stall <= 1'b0;
        forever begin
            k = $urandom_range(0, 99);
            if (k < 15) begin
                i_stall <= 1'b0;
                len = $urandom_range(20, 80);
            end else if (k < 60) begin
                i_stall <= 1'b0;
                len = $urandom_range(1, 4);
            end else if (k < 95) begin
                i_stall <= 1'b1;
                len = $urandom_range(1, 3);
            end else begin
                i_stall <= 1'b1;
                len = $urandom_range(10, 40);
            end
            repeat (len) @(posedge i_clk);
        end
    end

    task sender_pause();
        int k;
        int n;
        k = $urandom_range(0, 99);
        n = 0;
        if (!no_gaps) begin
            if (k < 50) n = 0;
            else if (k < 90) n = $urandom_range(1, 3);
            else if (k < 98) n = $urandom_range(4, 12);
            else n = $urandom_range(20, 60);
        end
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task send_request(logic [CMD_W-1:0] cmd, int x, int y, int pick);
        sender_pause();
        i_valid <= 1'b1;
        i_command <= cmd;
        i_cell_x <= XY_W'(x);
        i_cell_y <= XY_W'(y);
        i_random_pick <= PICK_W'(pick);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.note_request(cmd, XY_W'(x), XY_W'(y), PICK_W'(pick));
        requests_sent++;
    endtask

    task wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Both size registers are written back to back while the block is idle.
    task resize(int w, int h);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data <= CFG_W'(w);
        @(posedge i_clk);
        tracker.set_size(CFG_WIDTH, CFG_W'(w));
        i_cfg_index <= CFG_HEIGHT;
        i_cfg_data <= CFG_W'(h);
        @(posedge i_clk);
        tracker.set_size(CFG_HEIGHT, CFG_W'(h));
        i_cfg_we <= 1'b0;
    endtask

    task read_some_cell();
        if ($urandom_range(0, 3) == 0) begin
            send_request(CMD_READ, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
        end else begin
            send_request(CMD_READ, $urandom_range(0, tracker.columns() - 1),
                         $urandom_range(0, tracker.rows() - 1), $urandom);
        end
    endtask

    // An optional start, then carving steps mixed with reads, no-ops and the odd random request.
    task carve_run(bit restart, int cap);
        int n;
        int k;
        if (restart) begin
            if ($urandom_range(0, 4) == 0) begin
                send_request(CMD_START, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
            end else begin
                send_request(CMD_START, $urandom_range(0, tracker.columns() - 1),
                             $urandom_range(0, tracker.rows() - 1), $urandom);
            end
        end
        n = 0;
        while (n < cap && !tracker.maze_done() && tracker.stack_depth > 0) begin
            k = $urandom_range(0, 99);
            if (k < 78) begin
                send_request(CMD_STEP, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
            end else if (k < 90) begin
                read_some_cell();
            end else if (k < 95) begin
                send_request(CMD_NOP, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
            end else begin
                send_request(CMD_W'($urandom_range(0, 3)), $urandom_range(0, 31),
                             $urandom_range(0, 31), $urandom);
            end
            n++;
        end
        send_request(CMD_STEP, 0, 0, $urandom);
        read_some_cell();
    endtask

    function int small_size();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return 0;
        return $urandom_range(1, 6);
    endfunction

    initial begin
        int k;
        int w;
        int h;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_command <= CMD_NOP;
        i_cell_x <= '0;
        i_cell_y <= '0;
        i_random_pick <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Nothing started yet: a step finds an empty stack.
        send_request(CMD_STEP, 0, 0, 0);
        send_request(CMD_NOP, 31, 31, 255);
        send_request(CMD_READ, 31, 31, 0);
        send_request(CMD_READ, 0, 0, 8'hAA);

        // A single cell is finished as soon as it is started.
        resize(1, 1);
        send_request(CMD_START, 31, 31, 0);
        send_request(CMD_STEP, 0, 0, 0);
        send_request(CMD_READ, 0, 0, 0);

        // Zero sizes act as one.
        resize(0, 0);
        send_request(CMD_START, 5, 5, 0);
        send_request(CMD_STEP, 0, 0, 0);

        // A row of three: carve right, dead end pop, then carve left.
        resize(3, 1);
        send_request(CMD_START, 1, 0, 0);
        send_request(CMD_STEP, 0, 0, 0);
        send_request(CMD_STEP, 0, 0, 0);
        send_request(CMD_STEP, 0, 0, 7);
        send_request(CMD_READ, 0, 0, 0);

        // A column of three: carve bottom, pop, then carve top.
        resize(1, 3);
        send_request(CMD_START, 0, 1, 0);
        send_request(CMD_STEP, 0, 0, 2);
        send_request(CMD_STEP, 0, 0, 0);
        send_request(CMD_STEP, 0, 0, 0);

        // Oversized registers clamp to the full grid.
        resize(63, 40);
        send_request(CMD_START, 31, 31, 0);
        send_request(CMD_STEP, 0, 0, 255);
        send_request(CMD_READ, 31, 31, 0);

        while (requests_sent < RANDOM_REQUESTS + 21) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            k = $urandom_range(0, 99);
            if (k < 68) begin
                w = small_size();
                h = small_size();
                if ($urandom_range(0, 9) == 0) begin
                    w = $urandom_range(33, 63);
                    h = 1;
                end
                resize(w, h);
                carve_run(1'b1, 200);
            end else if (k < 76) begin
                if ($urandom_range(0, 1) == 0) begin
                    resize(32, $urandom_range(1, 2));
                end else begin
                    resize($urandom_range(1, 2), $urandom_range(32, 63));
                end
                carve_run(1'b1, 200);
            end else if (k < 81) begin
                resize(32, 32);
                carve_run(1'b1, 60);
            end else if (k < 88) begin
                carve_run(1'b1, 80);
            end else if (k < 94) begin
                resize(small_size(), small_size());
                carve_run(1'b0, 12);
            end else begin
                repeat (15) begin
                    send_request(CMD_W'($urandom_range(0, 3)), $urandom_range(0, 31),
                                 $urandom_range(0, 31), $urandom);
                end
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
